>>> design/tabt_pkg.sv
// Shared constants and types for the timed address ban table.
`default_nettype none
package tabt_pkg;

	localparam int ENTRIES    = 32;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ADDR_W     = 48;
	localparam int SECS_W     = 16;
	localparam int TIME_W     = 31;
	localparam int SLOT_W     = 5;
	localparam int PROD_W     = 26;
	localparam int MS_PER_SEC = 1000;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// Item under work, broadcast to every cell.
	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] now;
	} query_t;

	// Table write, broadcast to every cell.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] end_time;
	} wr_t;

	// Running search result handed from cell to cell.
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [IDX_W-1:0]  pick;
		logic [TIME_W-1:0] best;
		logic [IDX_W-1:0]  oldest;
		logic              hit;
		logic [IDX_W-1:0]  where_idx;
	} scan_t;

endpackage
`default_nettype wire

>>> design/tabt_cell.sv
// One table slot: holds an address and end time, updates the passing search token.
`default_nettype none
module tabt_cell
	import tabt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire query_t           q,
	input  wire wr_t              wr,
	input  wire scan_t            prev,
	output scan_t                 next
);

	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] end_q;
	scan_t             next_q;
	scan_t             nxt;
	logic              free;
	logic              active;

	assign free   = (end_q == '0) || (end_q < q.now);
	assign active = (end_q != '0) && (end_q > q.now);

	always_comb begin
		nxt = prev;
		if (q.op == OP_ADD) begin
			if (!prev.found) begin
				if (free) begin
					nxt.found = 1'b1;
					nxt.pick  = idx;
				end else if (end_q < prev.best) begin
					nxt.best   = end_q;
					nxt.oldest = idx;
				end
			end
		end else begin
			if (!prev.hit && active && (addr_q == q.addr)) begin
				nxt.hit       = 1'b1;
				nxt.where_idx = idx;
			end
		end
	end

	// Slot storage; the address needs no reset since a zero end time masks it.
	always_ff @(posedge clk) begin
		if (wr.we && (wr.idx == idx)) begin
			addr_q <= wr.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q  <= '0;
			next_q <= '0;
		end else begin
			if (wr.we && (wr.idx == idx)) begin
				end_q <= wr.end_time;
			end
			next_q <= nxt;
		end
	end

	assign next = next_q;

endmodule
`default_nettype wire

>>> design/timed_address_ban_table.sv
// Top level of the timed address ban table: input capture, cell chain and result register.
// An accepted input beat is registered, its search token walks the cell chain one slot per cycle,
// and the result is registered and then moved to the output register. The next item enters only
// after the result has moved to the output register; a held output beat stalls that move.
// Reset: arst_n clears every end time (all slots free) and all control state at once;
// no clearing pass is needed.
`default_nettype none
module timed_address_ban_table
	import tabt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata, low bit up: address[47:0], ban_seconds[63:48], now_ms[94:64], zero pad [95]
	input  wire logic [95:0] s_tdata,
	// s_tuser: operation[0]
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata, low bit up: is_banned[0], slot[5:1], zero pad [7:6]
	output logic [7:0]       m_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t            state_q;
	logic              start_q;
	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] now_q;
	logic [PROD_W-1:0] prod_q;
	logic              res_hit_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              m_valid_q;
	logic [7:0]        m_data_q;

	logic              in_fire;
	logic              out_free;
	query_t            query;
	wr_t               wr;
	scan_t             seed;
	scan_t             chain [ENTRIES+1];
	scan_t             last;
	logic [IDX_W-1:0]  chosen;
	logic [TIME_W:0]   end_sum;
	logic [TIME_W-1:0] end_time;
	logic [IDX_W+SLOT_W-1:0] chosen_ext;
	logic [IDX_W+SLOT_W-1:0] where_ext;
	logic [SLOT_W-1:0] chosen_slot;
	logic [SLOT_W-1:0] where_slot;
	logic [PROD_W-1:0] prod_d;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// Scale seconds to milliseconds at capture; the add happens when the scan ends.
	assign prod_d = PROD_W'(s_tdata[ADDR_W +: SECS_W]) * PROD_W'(MS_PER_SEC);

	assign query.op   = op_q;
	assign query.addr = addr_q;
	assign query.now  = now_q;

	// Seed the token: best starts at the top time so slot 0 wins ties on a full table.
	always_comb begin
		seed       = '0;
		seed.valid = start_q;
		seed.best  = TIME_MAX;
	end

	assign chain[0] = seed;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		tabt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(i)),
			.q      (query),
			.wr     (wr),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	assign last = chain[ENTRIES];

	// Free slot first, else the slot that ends soonest.
	assign chosen = last.found ? last.pick : last.oldest;

	// Saturate the end time at the field maximum.
	assign end_sum  = {1'b0, now_q} + (TIME_W+1)'(prod_q);
	assign end_time = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];

	// Only the low slot bits leave the block on a wide table.
	assign chosen_ext  = {{SLOT_W{1'b0}}, chosen};
	assign where_ext   = {{SLOT_W{1'b0}}, last.where_idx};
	assign chosen_slot = chosen_ext[SLOT_W-1:0];
	assign where_slot  = where_ext[SLOT_W-1:0];

	// Write the table as the token leaves the last cell.
	assign wr.we       = (state_q == ST_SCAN) && last.valid && (op_q == OP_ADD);
	assign wr.idx      = chosen;
	assign wr.addr     = addr_q;
	assign wr.end_time = end_time;

	// Capture the item, the result and the output data; no reset on payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= s_tuser[0];
			addr_q <= s_tdata[ADDR_W-1:0];
			now_q  <= s_tdata[ADDR_W+SECS_W +: TIME_W];
			prod_q <= prod_d;
		end
		if ((state_q == ST_SCAN) && last.valid) begin
			if (op_q == OP_ADD) begin
				res_hit_q  <= 1'b0;
				res_slot_q <= chosen_slot;
			end else begin
				res_hit_q  <= last.hit;
				res_slot_q <= last.hit ? where_slot : '0;
			end
		end
		if ((state_q == ST_DRAIN) && out_free) begin
			m_data_q <= {2'b00, res_slot_q, res_hit_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			start_q <= in_fire;
			// Drop the output beat once taken, unless a new result replaces it.
			if (m_valid_q && m_tready && (state_q != ST_DRAIN)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last.valid) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// Hold the result until the output register frees up.
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// The token enters the chain in the cycle after an accepted beat.
	a_start_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> start_q)
		else $error("search token not launched after input beat");

	// No token may enter or leave the chain while the block is ready for a new item.
	a_no_token_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!last.valid && !start_q))
		else $error("search token in flight while input is ready");

	// The token leaves the last cell only during a scan.
	a_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid |-> (state_q == ST_SCAN))
		else $error("search token left chain outside of a scan");

	// Table writes happen only for add items.
	a_write_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (op_q == OP_ADD) && (state_q == ST_SCAN))
		else $error("table write outside of an add scan");

endmodule
`default_nettype wire

>>> verif/tb.sv
// Testbench for the timed address ban table: directed and random ban traffic against a predictor.
`default_nettype none
module tb;
	import tabt_pkg::*;

	localparam int NUM_REQS    = 1750;
	localparam int MAX_WAIT    = 18;
	localparam int LONG_HOLD   = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int POOL_SIZE   = 6;
	localparam int RECENT_ENDS = 16;

	localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

	// One ban request as it crosses the input stream.
	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [SECS_W-1:0] secs;
		logic [TIME_W-1:0] now;
	} ban_req_t;

	// One verdict as it leaves on the output stream.
	typedef struct packed {
		logic              banned;
		logic [SLOT_W-1:0] slot;
	} ban_verdict_t;

	// Traffic shapes for the random part.
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_CHURN,
		MIX_NOISE
	} traffic_mix_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	timed_address_ban_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ban_req_t          pending_reqs[$];
	ban_verdict_t      awaited_verdicts[$];
	logic [TIME_W-1:0] recent_ends[$];

	// Predictor copy of the ban table.
	logic [TIME_W-1:0] table_end [ENTRIES];
	logic [ADDR_W-1:0] table_addr[ENTRIES];

	ban_req_t     offered_req;
	ban_verdict_t want;
	logic         in_fire;
	logic         out_fire;
	int           src_wait;
	int           sink_wait;
	int           hold_left;
	int           holds_done;
	int           total_reqs;
	int           reqs_sent      = 0;
	int           verdicts_seen  = 0;
	int           mismatches     = 0;
	int           adds_seen      = 0;
	int           checks_seen    = 0;
	int           hits_seen      = 0;
	int           evictions_seen = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// End time of a ban, saturated at the top of the time field.
	function automatic logic [TIME_W-1:0] ban_until(logic [TIME_W-1:0] now,
		logic [SECS_W-1:0] secs);
		logic [TIME_W+1:0] sum;
		sum = now + secs * MS_PER_SEC;
		return (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	// Apply one request to the predictor table and return the verdict it must produce.
	function automatic ban_verdict_t predict_verdict(ban_req_t r);
		ban_verdict_t      v;
		logic              found;
		int                pick;
		int                oldest;
		logic [TIME_W-1:0] best;
		v      = '0;
		found  = 1'b0;
		pick   = 0;
		oldest = 0;
		best   = '0;
		if (r.op == OP_ADD) begin
			// First free slot wins; otherwise track the soonest-ending entry, lowest index on a tie.
			for (int i = 0; i < ENTRIES; i++) begin
				if (!found) begin
					if (table_end[i] == '0 || table_end[i] < r.now) begin
						pick  = i;
						found = 1'b1;
					end else if (i == 0 || table_end[i] < best) begin
						best   = table_end[i];
						oldest = i;
					end
				end
			end
			if (!found) begin
				pick = oldest;
				evictions_seen++;
			end
			table_addr[pick] = r.addr;
			table_end[pick]  = ban_until(r.now, r.secs);
			v.slot = SLOT_W'(pick);
			adds_seen++;
		end else begin
			// Active means a nonzero end strictly after now; report the lowest such match.
			for (int i = 0; i < ENTRIES; i++) begin
				if (!v.banned && table_end[i] != '0 && table_end[i] > r.now &&
					table_addr[i] == r.addr) begin
					v.banned = 1'b1;
					v.slot   = SLOT_W'(i);
				end
			end
			checks_seen++;
			if (v.banned)
				hits_seen++;
		end
		return v;
	endfunction

	task automatic queue_req(logic op, logic [ADDR_W-1:0] addr, logic [SECS_W-1:0] secs,
		logic [TIME_W-1:0] now);
		ban_req_t r;
		r.op   = op;
		r.addr = addr;
		r.secs = secs;
		r.now  = now;
		pending_reqs.push_back(r);
		// Remember recent end times so later beats can land exactly on one.
		if (op == OP_ADD) begin
			recent_ends.push_back(ban_until(now, secs));
			if (recent_ends.size() > RECENT_ENDS)
				void'(recent_ends.pop_front());
		end
	endtask

	// Stimulus, reset and end of run.
	initial begin : stimulus
		traffic_mix_t      mix;
		int                span;
		int                p;
		logic [ADDR_W-1:0] pool[POOL_SIZE];
		logic [ADDR_W-1:0] addr;
		logic [SECS_W-1:0] secs;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] base;
		logic              op;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		in_fire   = 1'b0;
		out_fire  = 1'b0;
		src_wait  = 0;
		sink_wait = 0;
		hold_left = 0;
		holds_done = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			table_end[i]  = '0;
			table_addr[i] = '0;
		end

		// Directed: empty table, zero end time, exact-expiry boundary, saturation, bit patterns.
		queue_req(OP_CHECK, '0, '0, '0);
		queue_req(OP_ADD, '0, '0, '0);
		queue_req(OP_CHECK, '0, '0, '0);
		queue_req(OP_ADD, ADDR_ONES, '1, '0);
		queue_req(OP_CHECK, ADDR_ONES, '0, '0);
		queue_req(OP_ADD, 48'h0A00_0001_1F90, 16'd1, 31'd1000);
		queue_req(OP_CHECK, 48'h0A00_0001_1F90, '0, 31'd1999);
		queue_req(OP_CHECK, 48'h0A00_0001_1F90, '0, 31'd2000);
		queue_req(OP_ADD, 48'hC0A8_0102_6D6F, 16'd5, 31'd2000);
		queue_req(OP_ADD, 48'hAC10_0003_0050, 16'd1, 31'd2001);
		queue_req(OP_CHECK, 48'hC0A8_0102_6D6F, '0, 31'd6999);
		queue_req(OP_ADD, 48'h7F00_0001_FFFF, '1, TIME_MAX - 31'd5);
		queue_req(OP_CHECK, 48'h7F00_0001_FFFF, '0, TIME_MAX - 31'd1);
		queue_req(OP_CHECK, 48'h7F00_0001_FFFF, '0, TIME_MAX);
		queue_req(OP_ADD, 48'h0102_0304_0506, '0, TIME_MAX);
		queue_req(OP_CHECK, ADDR_ONES, '0, 31'd100);
		queue_req(OP_CHECK, 48'h0102_0304_0507, '0, 31'd5);
		queue_req(OP_CHECK, 48'h0102_0304_0506, '0, 31'd5);
		queue_req(OP_ADD, 48'hAAAA_AAAA_AAAA, 16'h5555, 31'h2AAA_AAAA);
		queue_req(OP_ADD, 48'h5555_5555_5555, 16'hAAAA, 31'h5555_5555);
		queue_req(OP_CHECK, 48'h5555_5555_5555, '0, 31'h5555_5555);
		queue_req(OP_CHECK, 48'hAAAA_AAAA_AAAA, '0, 31'h2AAA_AAAB);

		// Random: epochs of one traffic shape each. The first epoch fills the table so that
		// eviction of the soonest-ending entry is reached early.
		mix  = MIX_FILL;
		base = TIME_W'($urandom_range(1, 1000000));
		while (pending_reqs.size() < NUM_REQS) begin
			span = $urandom_range(60, 200);
			for (int k = 0; k < POOL_SIZE; k++)
				pool[k] = {$urandom, 16'($urandom)};
			if ($urandom_range(0, 9) == 0)
				pool[0] = '0;
			if ($urandom_range(0, 9) == 0)
				pool[1] = ADDR_ONES;
			// Near the top of time ends can saturate at the maximum, so entries can tie.
			if (mix == MIX_FILL && $urandom_range(0, 4) == 0)
				base = TIME_MAX - TIME_W'($urandom_range(0, 60000));
			for (int k = 0; k < span; k++) begin
				p    = $urandom_range(0, POOL_SIZE - 1);
				addr = pool[p];
				case (mix)
					MIX_FILL: begin
						// Long bans, slow clock: the table stays full and ends often tie.
						if ($urandom_range(0, 3) == 0)
							base = base + TIME_W'($urandom_range(1, 200));
						op   = ($urandom_range(0, 9) < 7) ? OP_ADD : OP_CHECK;
						secs = SECS_W'(10 * $urandom_range(1, 4));
						now  = base;
					end
					MIX_CHURN: begin
						// Short bans, fast clock: slots expire and are reused.
						base = base + TIME_W'($urandom_range(0, 1500));
						op   = $urandom_range(0, 1) ? OP_ADD : OP_CHECK;
						secs = SECS_W'($urandom_range(0, 3));
						now  = base;
					end
					default: begin
						op   = $urandom_range(0, 1) ? OP_ADD : OP_CHECK;
						secs = SECS_W'($urandom);
						now  = TIME_W'($urandom);
						if ($urandom_range(0, 1))
							addr = {$urandom, 16'($urandom)};
					end
				endcase
				// Land on a recent end time now and then: that entry is neither active nor free.
				if (recent_ends.size() > 0 && $urandom_range(0, 7) == 0)
					now = recent_ends[$urandom_range(0, recent_ends.size() - 1)];
				// Near misses: flip one bit of a lookup address.
				if (op == OP_CHECK && $urandom_range(0, 5) == 0)
					addr = addr ^ (48'd1 << $urandom_range(0, ADDR_W - 1));
				queue_req(op, addr, secs, now);
			end
			p   = $urandom_range(0, 19);
			mix = (p < 8) ? MIX_FILL : ((p < 15) ? MIX_CHURN : MIX_NOISE);
		end
		total_reqs = pending_reqs.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (reqs_sent < total_reqs)
			@(posedge clk);
		while (awaited_verdicts.size() > 0)
			@(posedge clk);
		// Let any stray beat show up before closing.
		repeat (ENTRIES + 8) @(posedge clk);

		$display("tb: %0d requests, %0d bans added, %0d lookups of which %0d hit",
			reqs_sent, adds_seen, checks_seen, hits_seen);
		$display("tb: %0d adds met a full table and evicted the soonest-ending entry",
			evictions_seen);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Input side: predict on every accepted beat.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			awaited_verdicts.push_back(predict_verdict(offered_req));
			reqs_sent++;
			in_fire <= 1'b1;
		end else
			in_fire <= 1'b0;
	end

	// Driver: hold a beat until taken, then wait a drawn number of cycles before the next.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (in_fire)
				src_wait = (((reqs_sent / 64) % 4) == 1) ? 0 : $urandom_range(0, MAX_WAIT);
			if (src_wait > 0) begin
				src_wait--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				offered_req = pending_reqs.pop_front();
				s_tdata  <= {1'b0, offered_req.now, offered_req.secs, offered_req.addr};
				s_tuser  <= offered_req.op;
				s_tvalid <= 1'b1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Output side: compare each verdict beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			verdicts_seen++;
			out_fire <= 1'b1;
			if (awaited_verdicts.size() == 0) begin
				$error("tb: verdict beat %h with no request outstanding", m_tdata);
				mismatches++;
			end else begin
				want = awaited_verdicts.pop_front();
				if (m_tdata[0] !== want.banned) begin
					$error("tb: is_banned expected %0d, got %0d", want.banned, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[5:1] !== want.slot) begin
					$error("tb: slot expected %0d, got %0d", want.slot, m_tdata[5:1]);
					mismatches++;
				end
			end
		end else
			out_fire <= 1'b0;
	end

	// Receiver: stall each verdict for a drawn number of cycles; drop ready during a long hold.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				sink_wait = (((verdicts_seen / 64) % 4) == 3) ? 0 : $urandom_range(0, MAX_WAIT);
			if (m_tvalid && sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else
				m_tready <= (sink_wait == 0) && (hold_left == 0);
		end
	end

	// Long back-pressure twice in the run, so the block backs up and stops taking beats.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0)
				hold_left <= hold_left - 1;
			else if (holds_done < 2 && verdicts_seen >= 300 + holds_done * 900) begin
				hold_left  <= LONG_HOLD;
				holds_done <= holds_done + 1;
			end
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$error("tb: no beat accepted for %0d cycles", STALL_LIMIT);
		$display("tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
design/tabt_pkg.sv
design/tabt_cell.sv
design/timed_address_ban_table.sv
verif/tb.sv
